// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/u8u2_pkg.sv =====
// ----------------------------------------------------------------------------
// u8u2_pkg
// Types and constants of the UTF-8 to UCS-2 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u2_pkg;

    localparam int BYTE_W  = 8;
    localparam int UNIT_W  = 16;
    localparam int COUNT_W = 11;
    localparam int LEN_W   = 3;
    localparam int HELD_W  = 2;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [UNIT_W-1:0]  REPLACEMENT_RESET = 16'h0020;
    localparam logic [COUNT_W-1:0] MAX_UNITS_RESET   = 11'd256;

    localparam logic [LEN_W-1:0] SEQ_LEN2 = 3'd2;
    localparam logic [LEN_W-1:0] SEQ_LEN3 = 3'd3;
    localparam logic [LEN_W-1:0] SEQ_LEN4 = 3'd4;

    typedef enum logic {
        REG_REPLACEMENT = 1'b0,
        REG_MAX_UNITS   = 1'b1
    } t_reg_idx;

    // results of one item: rep_count replacement units, then an optional final unit
    typedef struct packed {
        logic [HELD_W-1:0] rep_count;
        logic [UNIT_W-1:0] rep_code;
        logic              fin_valid;
        logic [UNIT_W-1:0] fin_code;
        logic              fin_term;
    } t_bundle;

endpackage

`default_nettype wire

// ===== hdl/u8u2_core.sv =====
// ----------------------------------------------------------------------------
// u8u2_core
// Sequence state and per-byte decode; produces the result bundle of an item.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u2_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic [u8u2_pkg::BYTE_W-1:0]   i_byte,
    input  wire logic [u8u2_pkg::UNIT_W-1:0]   i_replacement_unit,
    input  wire logic [u8u2_pkg::COUNT_W-1:0]  i_max_units,
    output u8u2_pkg::t_bundle                  o_bundle
);

    logic [u8u2_pkg::BYTE_W-1:0]  r_held [3];
    logic [u8u2_pkg::HELD_W-1:0]  r_held_count, n_held_count;
    logic [u8u2_pkg::LEN_W-1:0]   r_exp_len,    n_exp_len;
    logic [u8u2_pkg::COUNT_W-1:0] r_units,      n_units;
    logic                         r_limit,      n_limit;

    logic                         held_we;
    logic [u8u2_pkg::HELD_W-1:0]  held_idx;
    logic [3:0]                   ok;
    logic [u8u2_pkg::HELD_W-1:0]  flush_cnt;
    logic                         is_cont;
    logic                         is_bad;
    logic [u8u2_pkg::LEN_W-1:0]   lead_len;
    logic                         do_lead;
    logic                         lead_ok;
    logic [u8u2_pkg::UNIT_W-1:0]  dec_val;
    logic                         fin_unit;
    u8u2_pkg::t_bundle            bundle;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            ok[k] = !r_limit &&
                    (({1'b0, r_units} + 12'(k)) < {1'b0, i_max_units});
        end
        flush_cnt = 2'({1'b0, ok[0] && (r_held_count >= 2'd1)}) +
                    2'({1'b0, ok[1] && (r_held_count >= 2'd2)}) +
                    2'({1'b0, ok[2] && (r_held_count == 2'd3)});
        is_cont  = (i_byte[7:6] == 2'b10);
        is_bad   = is_cont || (i_byte[7:3] == 5'b11111);
        lead_len = !i_byte[5] ? u8u2_pkg::SEQ_LEN2 :
                   !i_byte[4] ? u8u2_pkg::SEQ_LEN3 : u8u2_pkg::SEQ_LEN4;
    end

    // value of the sequence completed by the current byte, or the replacement unit if it does not fit in 16 bits
    always_comb begin
        priority if (r_exp_len == u8u2_pkg::SEQ_LEN2) begin
            dec_val = {5'b0, r_held[0][4:0], i_byte[5:0]};
        end else if (r_exp_len == u8u2_pkg::SEQ_LEN3) begin
            dec_val = {r_held[0][3:0], r_held[1][5:0], i_byte[5:0]};
        end else if ({r_held[0][2:0], r_held[1][5:4]} != 5'b0) begin
            dec_val = i_replacement_unit;
        end else begin
            dec_val = {r_held[1][3:0], r_held[2][5:0], i_byte[5:0]};
        end
    end

    always_comb begin
        n_held_count     = r_held_count;
        n_exp_len        = r_exp_len;
        n_limit          = r_limit;
        held_we          = 1'b0;
        held_idx         = r_held_count;
        do_lead          = 1'b0;
        lead_ok          = 1'b0;
        bundle           = '0;
        bundle.rep_code  = i_replacement_unit;

        priority if (i_byte == '0) begin
            bundle.rep_count = flush_cnt;
            bundle.fin_valid = 1'b1;
            bundle.fin_term  = 1'b1;
            n_held_count     = '0;
            n_exp_len        = '0;
            n_limit          = 1'b0;
        end else if (r_held_count != '0) begin
            if (!ok[0]) begin
                n_limit      = 1'b1;
                n_held_count = '0;
                n_exp_len    = '0;
            end else if (is_cont) begin
                if (({1'b0, r_held_count} + 3'd1) == r_exp_len) begin
                    bundle.fin_valid = 1'b1;
                    bundle.fin_code  = dec_val;
                    n_held_count     = '0;
                    n_exp_len        = '0;
                end else begin
                    held_we      = 1'b1;
                    n_held_count = r_held_count + 2'd1;
                end
            end else begin
                bundle.rep_count = flush_cnt;
                n_held_count     = '0;
                n_exp_len        = '0;
                do_lead          = 1'b1;
                lead_ok          = ok[r_held_count];
            end
        end else begin
            n_held_count = '0;
            n_exp_len    = '0;
            do_lead      = 1'b1;
            lead_ok      = ok[0];
        end

        if (do_lead) begin
            priority if (!lead_ok) begin
                n_limit = 1'b1;
            end else if (!i_byte[7]) begin
                bundle.fin_valid = 1'b1;
                bundle.fin_code  = {8'b0, i_byte};
            end else if (is_bad) begin
                bundle.fin_valid = 1'b1;
                bundle.fin_code  = i_replacement_unit;
            end else begin
                held_we      = 1'b1;
                held_idx     = '0;
                n_held_count = 2'd1;
                n_exp_len    = lead_len;
            end
        end

        fin_unit = bundle.fin_valid && !bundle.fin_term;
        if (i_byte == '0) begin
            n_units = '0;
        end else begin
            n_units = 11'({1'b0, r_units} + 12'(bundle.rep_count) + 12'(fin_unit));
        end
    end

    assign o_bundle = bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_count <= '0;
            r_exp_len    <= '0;
            r_units      <= '0;
            r_limit      <= 1'b0;
        end else if (i_accept) begin
            r_held_count <= n_held_count;
            r_exp_len    <= n_exp_len;
            r_units      <= n_units;
            r_limit      <= n_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && held_we) begin
            r_held[held_idx] <= i_byte;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/u8u2_out.sv =====
// ----------------------------------------------------------------------------
// u8u2_out
// Result register: holds one item's bundle and hands out its units in order.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u2_out (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_load,
    input  wire u8u2_pkg::t_bundle            i_bundle,
    input  wire logic                         i_stall,
    output logic                              o_valid,
    output logic [u8u2_pkg::UNIT_W-1:0]       o_code_unit,
    output logic                              o_is_terminator,
    output logic                              o_run_last,
    output logic                              o_busy
);

    logic [u8u2_pkg::HELD_W-1:0] r_rep_left;
    logic                        r_fin_valid;
    logic [u8u2_pkg::UNIT_W-1:0] r_rep_code;
    logic [u8u2_pkg::UNIT_W-1:0] r_fin_code;
    logic                        r_fin_term;
    logic                        take;

    assign o_valid         = (r_rep_left != '0) || r_fin_valid;
    assign o_code_unit     = (r_rep_left != '0) ? r_rep_code : r_fin_code;
    assign o_is_terminator = (r_rep_left == '0) && r_fin_term;
    assign o_run_last      = (r_rep_left == '0) || ((r_rep_left == 2'd1) && !r_fin_valid);
    assign take            = o_valid && !i_stall;
    assign o_busy          = o_valid && !(take && o_run_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep_left  <= '0;
            r_fin_valid <= 1'b0;
        end else if (i_load) begin
            r_rep_left  <= i_bundle.rep_count;
            r_fin_valid <= i_bundle.fin_valid;
        end else if (take) begin
            if (r_rep_left != '0) begin
                r_rep_left <= r_rep_left - 2'd1;
            end else begin
                r_fin_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rep_code <= i_bundle.rep_code;
            r_fin_code <= i_bundle.fin_code;
            r_fin_term <= i_bundle.fin_term;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/utf8_to_ucs2_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder
// UTF-8 byte stream in, UCS-2 code units out, with string length limit.
// ----------------------------------------------------------------------------
// Input channel: one byte per item (i_in_valid / o_in_stall). Output channel:
// one code unit per item (o_out_valid / i_out_stall), with o_is_terminator on
// the unit that closes a string and o_run_last on the last unit caused by a
// given input byte. A byte may cause no unit (sequence byte held, or dropped
// past the limit) or up to four (held bytes flushed as replacements plus one).
// Latency: a byte's first unit is shown the cycle after the byte is taken.
// Throughput: one byte per cycle while each byte gives at most one unit and
// the output is not stalled; a byte giving more units holds the result
// register, and the next byte is taken in the cycle its last unit leaves.
// Stall: while i_out_stall is high the current unit holds, and o_in_stall
// rises once the result register holds a unit that is not leaving.
// Reset: synchronous, active low; clears the sequence state, the unit count
// and the result register, and loads replacement_unit 0x0020 and max_units
// 256. Registers sit at byte addresses 0 and 4 of the APB port; write them
// only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_ucs2_decoder (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [u8u2_pkg::BYTE_W-1:0]        i_in_byte,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [u8u2_pkg::UNIT_W-1:0]             o_code_unit,
    output logic                                    o_is_terminator,
    output logic                                    o_run_last,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [u8u2_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [u8u2_pkg::DATA_W-1:0]        pwdata,
    output logic [u8u2_pkg::DATA_W-1:0]             prdata,
    output logic                                    pready
);

    logic [u8u2_pkg::UNIT_W-1:0]  r_replacement_unit;
    logic [u8u2_pkg::COUNT_W-1:0] r_max_units;
    logic                         cfg_write;
    u8u2_pkg::t_reg_idx           reg_idx;
    u8u2_pkg::t_bundle            bundle;
    logic                         busy;
    logic                         in_accept;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = u8u2_pkg::t_reg_idx'(paddr[2]);

    always_comb begin
        unique case (reg_idx)
            u8u2_pkg::REG_REPLACEMENT: prdata = 32'(r_replacement_unit);
            u8u2_pkg::REG_MAX_UNITS:   prdata = 32'(r_max_units);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_replacement_unit <= u8u2_pkg::REPLACEMENT_RESET;
            r_max_units        <= u8u2_pkg::MAX_UNITS_RESET;
        end else if (cfg_write) begin
            unique case (reg_idx)
                u8u2_pkg::REG_REPLACEMENT: r_replacement_unit <= pwdata[15:0];
                u8u2_pkg::REG_MAX_UNITS:   r_max_units        <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = !i_rst_n || busy;
    assign in_accept  = i_in_valid && !o_in_stall;

    u8u2_core u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (in_accept),
        .i_byte             (i_in_byte),
        .i_replacement_unit (r_replacement_unit),
        .i_max_units        (r_max_units),
        .o_bundle           (bundle)
    );

    u8u2_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (in_accept),
        .i_bundle        (bundle),
        .i_stall         (i_out_stall),
        .o_valid         (o_out_valid),
        .o_code_unit     (o_code_unit),
        .o_is_terminator (o_is_terminator),
        .o_run_last      (o_run_last),
        .o_busy          (busy)
    );

`include "assert_macros.svh"

    `ASSERT_SAME(a_term_last, o_out_valid && o_is_terminator, o_run_last && (o_code_unit == '0), "terminator must be a zero unit and last of its item")
    `ASSERT_SAME(a_no_accept_mid_item, o_out_valid && !o_run_last, o_in_stall, "byte taken while an item still has units pending")
    `ASSERT_NEXT(a_zero_gives_term, in_accept && (i_in_byte == '0), o_out_valid, "zero byte gave no unit")
    `ASSERT_NEXT(a_hold_on_stall, o_out_valid && i_out_stall, o_out_valid && $stable(o_code_unit), "stalled unit changed")

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 to UCS-2 decoder.
// ----------------------------------------------------------------------------
// Bytes are fed from a queue, one item per handshake, with random gaps on
// the input and random stalls on the output. Each accepted byte runs through
// a local decoder model that queues the code units it must cause. Every unit
// that leaves the block is checked against the oldest queued unit. The run
// steps through several register settings, among them replacement 0x0000 and
// 0xFFFF and limits of 1 and 1024. It also includes one long output stall.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [u8u2_pkg::UNIT_W-1:0] code;
        logic                        term;
        logic                        last;
    } t_unit_exp;

    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          i_in_valid      = 1'b0;
    logic [u8u2_pkg::BYTE_W-1:0]   i_in_byte       = '0;
    logic                          i_out_stall     = 1'b0;
    logic                          psel            = 1'b0;
    logic                          penable         = 1'b0;
    logic                          pwrite          = 1'b0;
    logic [u8u2_pkg::ADDR_W-1:0]   paddr           = '0;
    logic [u8u2_pkg::DATA_W-1:0]   pwdata          = '0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    logic [u8u2_pkg::UNIT_W-1:0]   o_code_unit;
    logic                          o_is_terminator;
    logic                          o_run_last;
    logic [u8u2_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    utf8_to_ucs2_decoder uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_byte       (i_in_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_code_unit     (o_code_unit),
        .o_is_terminator (o_is_terminator),
        .o_run_last      (o_run_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // decoder model state and register copies
    logic [u8u2_pkg::BYTE_W-1:0]  held_q [3];
    logic [u8u2_pkg::HELD_W-1:0]  held_n    = '0;
    logic [u8u2_pkg::LEN_W-1:0]   seq_len   = '0;
    logic [u8u2_pkg::COUNT_W-1:0] units_out = '0;
    bit                           at_limit  = 1'b0;
    logic [u8u2_pkg::UNIT_W-1:0]  cfg_rep   = u8u2_pkg::REPLACEMENT_RESET;
    logic [u8u2_pkg::COUNT_W-1:0] cfg_max   = u8u2_pkg::MAX_UNITS_RESET;

    t_unit_exp                   step_q [$];
    t_unit_exp                   exp_units [$];
    logic [u8u2_pkg::BYTE_W-1:0] byte_feed [$];

    bit offer_open = 1'b0;
    bit idle_ok    = 1'b1;
    int gap_left   = 0;
    int stall_left = 0;
    int hold_left  = 0;
    int drv_quiet  = 0;
    int rcv_quiet  = 0;
    int idle_cnt   = 0;
    int n_bytes    = 0;
    int n_units    = 0;
    int n_terms    = 0;
    int n_fail     = 0;

    function automatic bit limit_hit();
        if (at_limit || units_out >= cfg_max) begin
            at_limit = 1'b1;
            held_n   = '0;
            seq_len  = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void push_unit(input logic [u8u2_pkg::UNIT_W-1:0] code, input bit term);
        t_unit_exp u;
        if (step_q.size() >= 4) return;
        u.code = code;
        u.term = term;
        u.last = 1'b0;
        step_q.push_back(u);
    endfunction

    function automatic void emit_char(input logic [20:0] value);
        logic [u8u2_pkg::UNIT_W-1:0] code;
        if (limit_hit()) return;
        code = (value > 21'h00FFFF) ? cfg_rep : value[u8u2_pkg::UNIT_W-1:0];
        push_unit(code, 1'b0);
        units_out = units_out + 1'b1;
    endfunction

    function automatic void flush_open();
        int n;
        n       = int'(held_n);
        held_n  = '0;
        seq_len = '0;
        for (int i = 0; i < n; i++) emit_char({5'd0, cfg_rep});
    endfunction

    function automatic void start_char(input logic [u8u2_pkg::BYTE_W-1:0] b);
        if (limit_hit()) return;
        if (b < 8'h80) begin
            emit_char({13'd0, b});
        end else if (b < 8'hC0 || b >= 8'hF8) begin
            emit_char({5'd0, cfg_rep});
        end else begin
            held_q[0] = b;
            held_n    = 2'd1;
            seq_len   = (b < 8'hE0) ? u8u2_pkg::SEQ_LEN2 :
                        (b < 8'hF0) ? u8u2_pkg::SEQ_LEN3 : u8u2_pkg::SEQ_LEN4;
        end
    endfunction

    function automatic void finish_char(input logic [u8u2_pkg::BYTE_W-1:0] b);
        logic [20:0] v;
        case (seq_len)
            u8u2_pkg::SEQ_LEN2: v = {10'd0, held_q[0][4:0], b[5:0]};
            u8u2_pkg::SEQ_LEN3: v = {5'd0, held_q[0][3:0], held_q[1][5:0], b[5:0]};
            default:  v = {held_q[0][2:0], held_q[1][5:0], held_q[2][5:0], b[5:0]};
        endcase
        held_n  = '0;
        seq_len = '0;
        emit_char(v);
    endfunction

    // units caused by one byte, appended to exp_units
    function automatic void decode_byte(input logic [u8u2_pkg::BYTE_W-1:0] b);
        t_unit_exp u;
        step_q.delete();
        if (b == 8'h00) begin
            if (!at_limit) flush_open();
            push_unit(16'h0000, 1'b1);
            held_n    = '0;
            seq_len   = '0;
            units_out = '0;
            at_limit  = 1'b0;
        end else if (held_n != '0 && seq_len > {1'b0, held_n}) begin
            if (!limit_hit()) begin
                if (b[7:6] == 2'b10) begin
                    if (({1'b0, held_n} + 3'd1) == seq_len) begin
                        finish_char(b);
                    end else begin
                        held_q[held_n] = b;
                        held_n = held_n + 1'b1;
                    end
                end else begin
                    flush_open();
                    start_char(b);
                end
            end
        end else begin
            held_n  = '0;
            seq_len = '0;
            start_char(b);
        end
        if (step_q.size() > 0) begin
            u = step_q.pop_back();
            u.last = 1'b1;
            step_q.push_back(u);
        end
        foreach (step_q[i]) exp_units.push_back(step_q[i]);
    endfunction

    // 0: no gap now; else a burst length of 1..6
    function automatic int burst_len(inout int quiet);
        if (!idle_ok) return 0;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        case ($urandom_range(0, 9))
            0, 1: return int'($urandom_range(1, 6));
            2: quiet = int'($urandom_range(8, 24));
            default: ;
        endcase
        return 0;
    endfunction

    // input side: acceptance and prediction
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            decode_byte(i_in_byte);
            void'(byte_feed.pop_front());
            offer_open = 1'b0;
            n_bytes++;
        end
    end

    // input side: drive
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!offer_open) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (byte_feed.size() == 0) begin
                i_in_valid <= 1'b0;
            end else begin
                gap_left = burst_len(drv_quiet);
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_valid <= 1'b1;
                    i_in_byte  <= byte_feed[0];
                    offer_open = 1'b1;
                end
            end
        end
    end

    // output side: stall, including the long hold
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            stall_left = burst_len(rcv_quiet);
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // output side: check
    always @(posedge i_clk) begin
        t_unit_exp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_units++;
            if (o_is_terminator) n_terms++;
            if (exp_units.size() == 0) begin
                n_fail++;
                if (n_fail <= MAX_REPORTS)
                    $display("unexpected unit: code %04h term %0b last %0b",
                             o_code_unit, o_is_terminator, o_run_last);
            end else begin
                want = exp_units.pop_front();
                if (o_code_unit !== want.code || o_is_terminator !== want.term ||
                    o_run_last !== want.last) begin
                    n_fail++;
                    if (n_fail <= MAX_REPORTS)
                        $display("unit %0d mismatch: exp %04h/%0b/%0b got %04h/%0b/%0b",
                                 n_units, want.code, want.term, want.last,
                                 o_code_unit, o_is_terminator, o_run_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cnt = 0;
        else
            idle_cnt++;
        if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(input u8u2_pkg::t_reg_idx idx,
                             input logic [u8u2_pkg::DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (idx == u8u2_pkg::REG_REPLACEMENT)
            cfg_rep = value[u8u2_pkg::UNIT_W-1:0];
        else
            cfg_max = value[u8u2_pkg::COUNT_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic settle_idle();
        while (byte_feed.size() != 0 || exp_units.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic feed(input logic [u8u2_pkg::BYTE_W-1:0] b []);
        foreach (b[i]) byte_feed.push_back(b[i]);
    endtask

    function automatic logic [u8u2_pkg::BYTE_W-1:0] cont_byte();
        logic [5:0] r;
        r = 6'($urandom_range(0, 63));
        return {2'b10, r};
    endfunction

    function automatic logic [u8u2_pkg::BYTE_W-1:0] lead_byte(input int len);
        logic [7:0] r;
        r = 8'($urandom_range(0, 255));
        case (len)
            2: return {3'b110, r[4:0]};
            3: return {4'b1110, r[3:0]};
            default: return {5'b11110, r[2:0]};
        endcase
    endfunction

    // mostly well-formed characters with random content, plus zero bytes, noise and
    // sequences cut short by a non-continuation byte
    task automatic add_text(input int count, input int zero_pct);
        int added;
        int r;
        int len;
        int k;
        logic [u8u2_pkg::BYTE_W-1:0] b;
        added = 0;
        while (added < count) begin
            r = int'($urandom_range(0, 99));
            if (r < zero_pct) begin
                byte_feed.push_back(8'h00);
                added++;
            end else if (r < zero_pct + 25) begin
                b = 8'($urandom_range(1, 127));
                byte_feed.push_back(b);
                added++;
            end else if (r < zero_pct + 65) begin
                len = int'($urandom_range(2, 4));
                byte_feed.push_back(lead_byte(len));
                for (int i = 1; i < len; i++) byte_feed.push_back(cont_byte());
                added += len;
            end else if (r < zero_pct + 80) begin
                len = int'($urandom_range(2, 4));
                k = int'($urandom_range(0, len - 2));
                byte_feed.push_back(lead_byte(len));
                for (int i = 0; i < k; i++) byte_feed.push_back(cont_byte());
                b = 8'($urandom_range(0, 255));
                while (b[7:6] == 2'b10) b = 8'($urandom_range(0, 255));
                byte_feed.push_back(b);
                added += k + 2;
            end else begin
                b = 8'($urandom_range(1, 255));
                byte_feed.push_back(b);
                added++;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, each length, out-of-range, stray, bad lead,
        // broken sequence, terminator with open sequence
        feed('{8'h00, 8'h7F, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC,
               8'hF0, 8'h9F, 8'h98, 8'h80, 8'hF0, 8'h8F, 8'hBF, 8'hBF,
               8'h80, 8'hFF, 8'hF0, 8'h9F, 8'h98, 8'h41, 8'hE2, 8'h82, 8'h00});
        add_text(20, 8);
        settle_idle();

        write_reg(u8u2_pkg::REG_REPLACEMENT, 32'h0000_FFFF);
        write_reg(u8u2_pkg::REG_MAX_UNITS, 32'd1);
        feed('{8'h41, 8'h42, 8'hE2, 8'h82, 8'hAC, 8'h00});
        add_text(12, 20);
        settle_idle();

        write_reg(u8u2_pkg::REG_REPLACEMENT, 32'h0000_0000);
        write_reg(u8u2_pkg::REG_MAX_UNITS, 32'd1024);
        @(posedge i_clk);
        hold_left = 50;
        feed('{8'h00, 8'hF0, 8'h9F, 8'h98, 8'h41, 8'hF0, 8'h9F, 8'h98, 8'h42,
               8'hE2, 8'h82, 8'hC3, 8'hF0, 8'h9F, 8'h98, 8'h43});
        add_text(16, 8);
        settle_idle();

        write_reg(u8u2_pkg::REG_REPLACEMENT, $urandom_range(0, 65535));
        write_reg(u8u2_pkg::REG_MAX_UNITS, 32'd3);
        add_text(8, 15);
        settle_idle();

        idle_ok = 1'b0;
        write_reg(u8u2_pkg::REG_REPLACEMENT, {16'd0, u8u2_pkg::REPLACEMENT_RESET});
        write_reg(u8u2_pkg::REG_MAX_UNITS, {21'd0, u8u2_pkg::MAX_UNITS_RESET});
        add_text(8, 8);
        settle_idle();
        repeat (12) @(posedge i_clk);

        $display("run covered %0d bytes in, %0d code units out, %0d string ends",
                 n_bytes, n_units, n_terms);
        $display("over five register settings, with gaps, stalls and one long hold");
        if (n_fail == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d failing units", n_fail);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
